// File: hdl/atk_pkg.sv
// Shared types and constants of the Atkin prime sieve.
`timescale 1ns / 1ps

package atk_pkg;

   // Bitmap geometry: one bit for every number 0..DEPTH-1.
   localparam int ADDR_W = 12;
   localparam int DEPTH  = 1 << ADDR_W;

   // Loop counters, squares and candidate sums.
   localparam int ROOT_W = 7;
   localparam int SQ_W   = 13;
   localparam int CALC_W = 16;

   // Index of the sweep counter; one bit wider than an address so that it can step past the limit.
   localparam int SWEEP_W = ADDR_W + 1;

   localparam logic [ADDR_W-1:0] LIMIT_FLOOR = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] LIMIT_RESET = ADDR_W'(DEPTH - 1);

   // Remainder by twelve: quotient estimate (n * 682) >> 13 is exact or one short.
   localparam int         MOD_W       = 5;
   localparam int         RECIP_W     = 10;
   localparam int         PROD_W      = ADDR_W + RECIP_W;
   localparam int         RECIP_SHIFT = 13;
   localparam int         QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(682);
   localparam logic [MOD_W-1:0]   MOD_BASE = MOD_W'(12);
   localparam logic [MOD_W-1:0]   RES_1    = MOD_W'(1);
   localparam logic [MOD_W-1:0]   RES_5    = MOD_W'(5);
   localparam logic [MOD_W-1:0]   RES_7    = MOD_W'(7);
   localparam logic [MOD_W-1:0]   RES_11   = MOD_W'(11);

   // First number whose square multiples are removed.
   localparam logic [ROOT_W-1:0] FIRST_SQUARE_BASE = ROOT_W'(5);
   localparam logic [SQ_W-1:0]   FIRST_SQUARE      = SQ_W'(25);

   localparam logic [ADDR_W-1:0] PRIME_TWO   = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] PRIME_THREE = ADDR_W'(3);

   localparam logic OP_BUILD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CAND_4X2_PLUS,
      CAND_3X2_PLUS,
      CAND_3X2_MINUS
   } cand_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUERY,
      ST_CLEAR,
      ST_ROOT,
      ST_CAND,
      ST_MULT,
      ST_MOD,
      ST_TOGGLE,
      ST_MARK_READ,
      ST_MARK_CHECK,
      ST_SWEEP,
      ST_SET_TWO,
      ST_SET_THREE,
      ST_DONE
   } state_type;

endpackage

// File: hdl/atk_req_if.sv
// Request channel of the Atkin prime sieve.
`timescale 1ns / 1ps

interface atk_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [atk_pkg::ADDR_W-1:0] number;

   modport source (output valid, output op, output number, input ready);
   modport sink   (input valid, input op, input number, output ready);
endinterface

// File: hdl/atk_rsp_if.sv
// Response channel of the Atkin prime sieve.
`timescale 1ns / 1ps

interface atk_rsp_if;
   logic valid;
   logic ready;
   logic is_prime;
   logic build_done;
   logic out_of_range;

   modport source (output valid, output is_prime, output build_done, output out_of_range,
                   input ready);
   modport sink   (input valid, input is_prime, input build_done, input out_of_range,
                   output ready);
endinterface

// File: hdl/atkin_prime_sieve.sv
// Top level of the Atkin prime sieve: bitmap memory, build sequencer and query path.
`timescale 1ns / 1ps

// The block keeps a 4096 x 1 primality bitmap in a synchronous memory.
// Request words arrive on req_chan: op = build rebuilds the bitmap for
// 0..limit, op = query asks for the bit of one number. Every request word
// produces exactly one response word on rsp_chan. A build answers with
// build_done set. A query answers with is_prime, and it sets out_of_range
// for numbers above the limit. The limit comes from csr_write_data,
// written with csr_write_enable; the user must write it only while the
// block is idle, which the block itself does not enforce. Values below
// three act as three. Queries run at one word per cycle while the receiver
// does not stall; each query needs one registered memory read, and its
// response word is loaded into the output register once that is free.
// A build clears the memory one entry a cycle, finds R = floor(sqrt(limit))
// and steps through 3 * R * R toggle candidates. Each one in range goes
// through the multiply and remainder states, a matching one has its bit
// read and inverted, and every removed square multiple takes one write.
// Reset is synchronous and clears the control state. The limit returns to
// 4095 and a flag marks the bitmap as not built, so queries read zero
// until the first build; no clearing pass runs after reset.
// The response sits in an output register. While the receiver stalls, that
// word is held and at most one more request word is taken, which then waits.
module atkin_prime_sieve (
   input  logic                        clock,
   input  logic                        reset,
   atk_req_if.sink                     req_chan,
   atk_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [atk_pkg::ADDR_W-1:0]  csr_write_data
);

   // Bitmap storage, no reset; the built flag covers the time before the first build.
   logic bitmap_mem [atk_pkg::DEPTH];

   logic                          mem_we;
   logic [atk_pkg::ADDR_W-1:0]    mem_waddr;
   logic                          mem_wdata;
   logic                          mem_re;
   logic [atk_pkg::ADDR_W-1:0]    mem_raddr;
   logic                          rd_bit_ff;

   atk_pkg::state_type            state_ff, state_in;
   logic [atk_pkg::ADDR_W-1:0]    limit_ff;
   logic [atk_pkg::ADDR_W-1:0]    eff_limit;
   logic                          built_ff, built_in;

   // Build loop registers.
   logic [atk_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [atk_pkg::SQ_W-1:0]      root_sq_ff, root_sq_in;
   logic [atk_pkg::ROOT_W-1:0]    outer_ff, outer_in;
   logic [atk_pkg::SQ_W-1:0]      outer_sq_ff, outer_sq_in;
   logic [atk_pkg::ROOT_W-1:0]    inner_ff, inner_in;
   logic [atk_pkg::SQ_W-1:0]      inner_sq_ff, inner_sq_in;
   atk_pkg::cand_type             cand_ff, cand_in;
   logic [atk_pkg::ADDR_W-1:0]    cand_num_ff, cand_num_in;
   logic [atk_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [atk_pkg::SWEEP_W-1:0]   sweep_ff, sweep_in;
   logic [atk_pkg::ROOT_W-1:0]    base_ff, base_in;
   logic [atk_pkg::SQ_W-1:0]      base_sq_ff, base_sq_in;

   // Query and response registers.
   logic [atk_pkg::ADDR_W-1:0]    qnum_ff, qnum_in;
   logic                          rsp_valid_ff;
   logic                          is_prime_ff, is_prime_in;
   logic                          build_done_ff, build_done_in;
   logic                          out_of_range_ff, out_of_range_in;
   logic                          rsp_load;
   logic                          out_free;
   logic                          req_ready;

   // Next position in the candidate loop.
   atk_pkg::cand_type             adv_cand;
   logic [atk_pkg::ROOT_W-1:0]    adv_outer, adv_inner;
   logic [atk_pkg::SQ_W-1:0]      adv_outer_sq, adv_inner_sq;
   logic                          adv_last;

   // Candidate arithmetic.
   logic [atk_pkg::CALC_W-1:0]    outer_sq_wide, inner_sq_wide, three_x2;
   logic [atk_pkg::CALC_W-1:0]    cand_sum;
   logic                          cand_allowed;
   logic [atk_pkg::PROD_W-1:0]    recip_prod;
   logic [atk_pkg::ADDR_W-1:0]    quot_times_12, rem_raw;
   logic [atk_pkg::MOD_W-1:0]     rem_small, rem12;
   logic                          rem_match;

   // Square base for the next marked number.
   logic [atk_pkg::ROOT_W-1:0]    next_base;
   logic [atk_pkg::SQ_W-1:0]      next_base_sq;

   // Limit clamp: values below three are held at three.
   assign eff_limit = (limit_ff < atk_pkg::LIMIT_FLOOR) ? atk_pkg::LIMIT_FLOOR : limit_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_prime     = is_prime_ff;
   assign rsp_chan.build_done   = build_done_ff;
   assign rsp_chan.out_of_range = out_of_range_ff;

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_bit_ff <= bitmap_mem[mem_raddr];
      end
   end

   // Candidate loop stepping: three candidates per (x, y), y inner, x outer.
   always_comb begin
      adv_cand     = cand_ff;
      adv_outer    = outer_ff;
      adv_outer_sq = outer_sq_ff;
      adv_inner    = inner_ff;
      adv_inner_sq = inner_sq_ff;
      adv_last     = 1'b0;
      case (cand_ff)
         atk_pkg::CAND_4X2_PLUS: adv_cand = atk_pkg::CAND_3X2_PLUS;
         atk_pkg::CAND_3X2_PLUS: adv_cand = atk_pkg::CAND_3X2_MINUS;
         default: begin
            adv_cand = atk_pkg::CAND_4X2_PLUS;
            if (inner_ff == root_ff) begin
               adv_inner    = atk_pkg::ROOT_W'(1);
               adv_inner_sq = atk_pkg::SQ_W'(1);
               adv_outer    = outer_ff + atk_pkg::ROOT_W'(1);
               adv_outer_sq = outer_sq_ff + atk_pkg::SQ_W'({outer_ff, 1'b1});
               adv_last     = (outer_ff == root_ff);
            end else begin
               adv_inner    = inner_ff + atk_pkg::ROOT_W'(1);
               adv_inner_sq = inner_sq_ff + atk_pkg::SQ_W'({inner_ff, 1'b1});
            end
         end
      endcase
   end

   // Candidate value and the remainder by twelve.
   always_comb begin
      outer_sq_wide = atk_pkg::CALC_W'(outer_sq_ff);
      inner_sq_wide = atk_pkg::CALC_W'(inner_sq_ff);
      three_x2      = (outer_sq_wide << 1) + outer_sq_wide;
      cand_allowed  = 1'b1;
      case (cand_ff)
         atk_pkg::CAND_4X2_PLUS: cand_sum = (outer_sq_wide << 2) + inner_sq_wide;
         atk_pkg::CAND_3X2_PLUS: cand_sum = three_x2 + inner_sq_wide;
         default: begin
            cand_allowed = (outer_ff > inner_ff);
            cand_sum     = three_x2 - inner_sq_wide;
         end
      endcase

      recip_prod    = atk_pkg::PROD_W'(cand_num_ff) * atk_pkg::PROD_W'(atk_pkg::RECIP);
      quot_times_12 = atk_pkg::ADDR_W'({quot_ff, 3'b000}) + atk_pkg::ADDR_W'({quot_ff, 2'b00});
      rem_raw       = cand_num_ff - quot_times_12;
      rem_small     = rem_raw[atk_pkg::MOD_W-1:0];
      rem12         = (rem_small >= atk_pkg::MOD_BASE) ? rem_small - atk_pkg::MOD_BASE
                                                       : rem_small;
      case (cand_ff)
         atk_pkg::CAND_4X2_PLUS: rem_match = (rem12 == atk_pkg::RES_1) ||
                                             (rem12 == atk_pkg::RES_5);
         atk_pkg::CAND_3X2_PLUS: rem_match = (rem12 == atk_pkg::RES_7);
         default:                rem_match = (rem12 == atk_pkg::RES_11);
      endcase

      next_base    = base_ff + atk_pkg::ROOT_W'(1);
      next_base_sq = base_sq_ff + atk_pkg::SQ_W'({base_ff, 1'b1});
   end

   // Sequencer: next state, memory port and response load.
   always_comb begin
      state_in        = state_ff;
      built_in        = built_ff;
      root_in         = root_ff;
      root_sq_in      = root_sq_ff;
      outer_in        = outer_ff;
      outer_sq_in     = outer_sq_ff;
      inner_in        = inner_ff;
      inner_sq_in     = inner_sq_ff;
      cand_in         = cand_ff;
      cand_num_in     = cand_num_ff;
      quot_in         = quot_ff;
      sweep_in        = sweep_ff;
      base_in         = base_ff;
      base_sq_in      = base_sq_ff;
      qnum_in         = qnum_ff;
      mem_we          = 1'b0;
      mem_waddr       = cand_num_ff;
      mem_wdata       = 1'b0;
      mem_re          = 1'b0;
      mem_raddr       = req_chan.number;
      rsp_load        = 1'b0;
      is_prime_in     = 1'b0;
      build_done_in   = 1'b0;
      out_of_range_in = 1'b0;
      req_ready       = 1'b0;

      unique case (state_ff)
         atk_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end

         atk_pkg::ST_QUERY: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               out_of_range_in = (qnum_ff > eff_limit);
               is_prime_in     = !(qnum_ff > eff_limit) && built_ff && rd_bit_ff;
               req_ready       = 1'b1;
               state_in        = atk_pkg::ST_IDLE;
            end
         end

         atk_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[atk_pkg::ADDR_W-1:0];
            mem_wdata = 1'b0;
            sweep_in  = sweep_ff + atk_pkg::SWEEP_W'(1);
            if (sweep_ff[atk_pkg::ADDR_W-1:0] == atk_pkg::ADDR_W'(atk_pkg::DEPTH - 1)) begin
               root_in    = '0;
               root_sq_in = atk_pkg::SQ_W'(1);
               state_in   = atk_pkg::ST_ROOT;
            end
         end

         atk_pkg::ST_ROOT: begin
            // root_sq holds (root + 1) squared.
            if (root_sq_ff <= atk_pkg::SQ_W'(eff_limit)) begin
               root_in    = root_ff + atk_pkg::ROOT_W'(1);
               root_sq_in = root_sq_ff + atk_pkg::SQ_W'({root_ff, 1'b1})
                            + atk_pkg::SQ_W'(2);
            end else begin
               outer_in    = atk_pkg::ROOT_W'(1);
               outer_sq_in = atk_pkg::SQ_W'(1);
               inner_in    = atk_pkg::ROOT_W'(1);
               inner_sq_in = atk_pkg::SQ_W'(1);
               cand_in     = atk_pkg::CAND_4X2_PLUS;
               state_in    = atk_pkg::ST_CAND;
            end
         end

         atk_pkg::ST_CAND: begin
            cand_num_in = cand_sum[atk_pkg::ADDR_W-1:0];
            if (cand_allowed && (cand_sum <= atk_pkg::CALC_W'(eff_limit))) begin
               state_in = atk_pkg::ST_MULT;
            end else begin
               cand_in     = adv_cand;
               outer_in    = adv_outer;
               outer_sq_in = adv_outer_sq;
               inner_in    = adv_inner;
               inner_sq_in = adv_inner_sq;
               if (adv_last) begin
                  base_in    = atk_pkg::FIRST_SQUARE_BASE;
                  base_sq_in = atk_pkg::FIRST_SQUARE;
                  state_in   = atk_pkg::ST_MARK_READ;
               end
            end
         end

         atk_pkg::ST_MULT: begin
            quot_in  = recip_prod[atk_pkg::PROD_W-1:atk_pkg::RECIP_SHIFT];
            state_in = atk_pkg::ST_MOD;
         end

         atk_pkg::ST_MOD: begin
            if (rem_match) begin
               mem_re    = 1'b1;
               mem_raddr = cand_num_ff;
               state_in  = atk_pkg::ST_TOGGLE;
            end else begin
               cand_in     = adv_cand;
               outer_in    = adv_outer;
               outer_sq_in = adv_outer_sq;
               inner_in    = adv_inner;
               inner_sq_in = adv_inner_sq;
               state_in    = atk_pkg::ST_CAND;
               if (adv_last) begin
                  base_in    = atk_pkg::FIRST_SQUARE_BASE;
                  base_sq_in = atk_pkg::FIRST_SQUARE;
                  state_in   = atk_pkg::ST_MARK_READ;
               end
            end
         end

         atk_pkg::ST_TOGGLE: begin
            mem_we      = 1'b1;
            mem_waddr   = cand_num_ff;
            mem_wdata   = !rd_bit_ff;
            cand_in     = adv_cand;
            outer_in    = adv_outer;
            outer_sq_in = adv_outer_sq;
            inner_in    = adv_inner;
            inner_sq_in = adv_inner_sq;
            state_in    = atk_pkg::ST_CAND;
            if (adv_last) begin
               base_in    = atk_pkg::FIRST_SQUARE_BASE;
               base_sq_in = atk_pkg::FIRST_SQUARE;
               state_in   = atk_pkg::ST_MARK_READ;
            end
         end

         atk_pkg::ST_MARK_READ: begin
            if (base_ff > root_ff) begin
               state_in = atk_pkg::ST_SET_TWO;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = atk_pkg::ADDR_W'(base_ff);
               state_in  = atk_pkg::ST_MARK_CHECK;
            end
         end

         atk_pkg::ST_MARK_CHECK: begin
            if (rd_bit_ff) begin
               sweep_in = atk_pkg::SWEEP_W'(base_sq_ff);
               state_in = atk_pkg::ST_SWEEP;
            end else begin
               base_in    = next_base;
               base_sq_in = next_base_sq;
               state_in   = atk_pkg::ST_MARK_READ;
            end
         end

         atk_pkg::ST_SWEEP: begin
            if (sweep_ff <= atk_pkg::SWEEP_W'(eff_limit)) begin
               mem_we    = 1'b1;
               mem_waddr = sweep_ff[atk_pkg::ADDR_W-1:0];
               mem_wdata = 1'b0;
               sweep_in  = sweep_ff + atk_pkg::SWEEP_W'(base_sq_ff);
            end else begin
               base_in    = next_base;
               base_sq_in = next_base_sq;
               state_in   = atk_pkg::ST_MARK_READ;
            end
         end

         atk_pkg::ST_SET_TWO: begin
            mem_we    = 1'b1;
            mem_waddr = atk_pkg::PRIME_TWO;
            mem_wdata = 1'b1;
            state_in  = atk_pkg::ST_SET_THREE;
         end

         atk_pkg::ST_SET_THREE: begin
            mem_we    = 1'b1;
            mem_waddr = atk_pkg::PRIME_THREE;
            mem_wdata = 1'b1;
            built_in  = 1'b1;
            state_in  = atk_pkg::ST_DONE;
         end

         atk_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               build_done_in = 1'b1;
               state_in      = atk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = atk_pkg::ST_IDLE;
         end
      endcase

      // A new request word may enter whenever the port is ready.
      if (req_ready && req_chan.valid) begin
         if (req_chan.op == atk_pkg::OP_QUERY) begin
            mem_re    = 1'b1;
            mem_raddr = req_chan.number;
            qnum_in   = req_chan.number;
            state_in  = atk_pkg::ST_QUERY;
         end else begin
            sweep_in = '0;
            built_in = 1'b0;
            state_in = atk_pkg::ST_CLEAR;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= atk_pkg::ST_IDLE;
         limit_ff     <= atk_pkg::LIMIT_RESET;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         outer_ff     <= '0;
         inner_ff     <= '0;
         sweep_ff     <= '0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         root_ff  <= root_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
         sweep_ff <= sweep_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      root_sq_ff  <= root_sq_in;
      outer_sq_ff <= outer_sq_in;
      inner_sq_ff <= inner_sq_in;
      cand_ff     <= cand_in;
      cand_num_ff <= cand_num_in;
      quot_ff     <= quot_in;
      base_ff     <= base_in;
      base_sq_ff  <= base_sq_in;
      qnum_ff     <= qnum_in;
      if (rsp_load) begin
         is_prime_ff     <= is_prime_in;
         build_done_ff   <= build_done_in;
         out_of_range_ff <= out_of_range_in;
      end
   end

endmodule
